// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Table geometry, status codes and the request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SIZE = 13;
    localparam int KEY_BITS   = 31;

    localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

    localparam int RECIP_SHIFT = KEY_BITS + SLOT_W;
    localparam int RECIP_W     = KEY_BITS + 1;
    localparam int PROD_W      = KEY_BITS + RECIP_W;
    localparam int QUOT_W      = RECIP_W - SLOT_W;

    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [30:0] key;
    } lpht_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [3:0] probes;
    } lpht_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing table with linear probing; inserts and searches keys.
// ----------------------------------------------------------------------------
// A request on the s_ channel carries a mode (insert or search) and a key.
// Each request yields exactly one response on the m_ channel with a status,
// the slot that was stored or found, and the probe count of a search.
// The block works on one request at a time. At acceptance the key is
// multiplied by a fixed reciprocal of the table size; in the next cycle the
// home slot is formed from the quotient and its entry of the key RAM is read.
// The probe loop then checks one slot per cycle over 1 to TABLE_SIZE slots,
// and the emit state loads the response into the output register once it is
// free. s_ready rises together with m_valid, so a new request is accepted
// only after the response of the last one has been loaded.
// Reset clears every occupancy flag, so the table starts empty; the key RAM
// holds no reset value and its data decides a match only where a flag is set.
// If the receiver stalls, the response waits in the output register, and a
// finished request whose response cannot yet be loaded holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire lpht_req_t s_req,
    output logic           m_valid,
    input  wire logic      m_ready,
    output lpht_rsp_t      m_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TABLE_SIZE-1:0] used_reg, used_next;
    lpht_rsp_t             pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    lpht_rsp_t             m_rsp_reg, m_rsp_next;

    logic [PROD_W-1:0]     hash_prod;
    logic [SLOT_W-1:0]     home_slot;
    logic [SLOT_W-1:0]     pos_inc;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  last_probe;
    logic                  slot_empty;
    logic                  key_match;

    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    logic [KEY_BITS-1:0]   ram_rd_data;

    lpht_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (key_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign hash_prod  = PROD_W'(KEY_BITS'(s_req.key)) * PROD_W'(RECIP_M);
    assign home_slot  = key_reg[SLOT_W-1:0] - SLOT_W'(quot_reg * QUOT_W'(TABLE_SIZE));
    assign pos_inc    = (pos_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;
    assign cnt_inc    = cnt_reg + 1'b1;
    assign last_probe = (cnt_inc == CNT_W'(TABLE_SIZE));
    assign slot_empty = !used_reg[pos_reg];
    assign key_match  = (ram_rd_data == key_reg);

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        quot_next    = quot_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        used_next    = used_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_req.mode;
                    key_next   = KEY_BITS'(s_req.key);
                    quot_next  = hash_prod[PROD_W-1:RECIP_SHIFT];
                    pos_next   = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = home_slot;
                pos_next    = home_slot;
                cnt_next    = '0;
                state_next  = S_PROBE;
            end
            S_PROBE: begin
                if (mode_reg == MODE_INSERT) begin
                    if (slot_empty || key_match) begin
                        ram_wr_en          = 1'b1;
                        used_next[pos_reg] = 1'b1;
                        pend_next.status   = STATUS_OK;
                        pend_next.slot     = 4'(pos_reg);
                        pend_next.probes   = '0;
                        state_next         = S_EMIT;
                    end else if (last_probe) begin
                        pend_next.status = STATUS_FULL;
                        pend_next.slot   = '0;
                        pend_next.probes = '0;
                        state_next       = S_EMIT;
                    end
                end else begin
                    if (!slot_empty && key_match) begin
                        pend_next.status = STATUS_OK;
                        pend_next.slot   = 4'(pos_reg);
                        pend_next.probes = 4'(cnt_inc);
                        state_next       = S_EMIT;
                    end else if (slot_empty || last_probe) begin
                        pend_next.status = STATUS_MISS;
                        pend_next.slot   = '0;
                        pend_next.probes = 4'(cnt_inc);
                        state_next       = S_EMIT;
                    end
                end
                if (state_next == S_PROBE) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_inc;
                    pos_next    = pos_inc;
                    cnt_next    = cnt_inc;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_rsp_next   = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        quot_reg  <= quot_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        pend_reg  <= pend_next;
        m_rsp_reg <= m_rsp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level properties of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_checker
    import lpht_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire lpht_req_t s_req,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire lpht_rsp_t m_rsp
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Response valid after reset.");

    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("Stalled response changed.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Second request accepted while busy.");

    a_fail_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != STATUS_OK) |-> (m_rsp.slot == '0))
        else $error("Failed request reports a slot.");

    a_full_no_probes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == STATUS_FULL) |-> (m_rsp.probes == '0))
        else $error("Table full response reports probes.");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
